// ===== hdl/sdx_pkg.sv =====
// Shared types, constants and character-class functions for the soundex encoder.
// No dependencies; every other file imports this package.
package sdx_pkg;

  // Digit codes kept per word by default, and digit fields on the result beat
  localparam int unsigned CODE_DIGITS_DEF = 4;
  localparam int unsigned OUT_CODES       = 4;
  localparam int unsigned CODE_W          = 3;

  // ASCII bounds and the stand-in lead for non-letters
  localparam logic [7:0] ASCII_UP_A   = 8'd65;
  localparam logic [7:0] ASCII_UP_Z   = 8'd90;
  localparam logic [7:0] ASCII_LO_A   = 8'd97;
  localparam logic [7:0] ASCII_LO_Z   = 8'd122;
  localparam logic [7:0] CASE_OFFSET  = 8'd32;
  localparam logic [7:0] LEAD_DEFAULT = 8'd90;

  // Digit code values
  localparam logic [CODE_W-1:0] CODE_NONE   = 3'd0;
  localparam logic [CODE_W-1:0] CODE_LABIAL = 3'd1;
  localparam logic [CODE_W-1:0] CODE_SIBIL  = 3'd2;
  localparam logic [CODE_W-1:0] CODE_DENTAL = 3'd3;
  localparam logic [CODE_W-1:0] CODE_LATERL = 3'd4;
  localparam logic [CODE_W-1:0] CODE_NASAL  = 3'd5;
  localparam logic [CODE_W-1:0] CODE_RHOTIC = 3'd6;

  typedef logic [CODE_W-1:0] code_t;

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } char_beat_t;

  typedef struct packed {
    logic [7:0] lead_char;
    code_t      code_one;
    code_t      code_two;
    code_t      code_three;
    code_t      code_four;
  } code_beat_t;

  // Map a byte of either case to its digit code; anything else has none
  function automatic code_t letter_code(input logic [7:0] c);
    logic [7:0] lc;
    code_t      code;
    lc = (c >= ASCII_UP_A && c <= ASCII_UP_Z) ? c + CASE_OFFSET : c;
    unique case (lc)
      "b", "f", "p", "v":                     code = CODE_LABIAL;
      "c", "g", "j", "k", "q", "s", "x", "z": code = CODE_SIBIL;
      "d", "t":                               code = CODE_DENTAL;
      "l":                                    code = CODE_LATERL;
      "m", "n":                               code = CODE_NASAL;
      "r":                                    code = CODE_RHOTIC;
      default:                                code = CODE_NONE;
    endcase
    return code;
  endfunction

  // Upper-case a letter; any other byte becomes the default lead
  function automatic logic [7:0] lead_of(input logic [7:0] c);
    logic [7:0] lead;
    if (c >= ASCII_LO_A && c <= ASCII_LO_Z) begin
      lead = c - CASE_OFFSET;
    end else if (c >= ASCII_UP_A && c <= ASCII_UP_Z) begin
      lead = c;
    end else begin
      lead = LEAD_DEFAULT;
    end
    return lead;
  endfunction

endpackage

// ===== hdl/sdx_word.sv =====
// Per-word state of the soundex encoder: lead character, run tracking and digit store.
// Depends on sdx_pkg; presents the finished code of the word as it would stand
// after the current character.
module sdx_word import sdx_pkg::*; #(
  parameter int unsigned CODE_DIGITS = CODE_DIGITS_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       accept,
  input  char_beat_t beat,
  output code_beat_t result
);

  localparam int unsigned CNT_W = $clog2(CODE_DIGITS + 1);

  logic             at_start;
  logic [7:0]       first_char;
  code_t            prev_code;
  logic [CNT_W-1:0] count;
  code_t            store [CODE_DIGITS];

  code_t            cur_code;
  logic             take;
  logic [7:0]       first_next;
  code_t            store_next [CODE_DIGITS];
  code_t            codes_out [OUT_CODES];

  // Classify the character and decide whether it fills a digit slot
  always_comb begin
    cur_code   = letter_code(beat.ch);
    take       = !at_start && (cur_code != CODE_NONE) && (cur_code != prev_code) &&
                 (count < CNT_W'(CODE_DIGITS));
    first_next = at_start ? beat.ch : first_char;
    for (int k = 0; k < CODE_DIGITS; k++) begin
      store_next[k] = (take && count == CNT_W'(k)) ? cur_code : store[k];
    end
  end

  // Route stored digits to the fixed result fields; missing digits pad with zero
  for (genvar k = 0; k < OUT_CODES; k++) begin : g_out
    if (k < CODE_DIGITS) begin : g_used
      assign codes_out[k] = store_next[k];
    end else begin : g_pad
      assign codes_out[k] = CODE_NONE;
    end
  end

  assign result.lead_char  = lead_of(first_next);
  assign result.code_one   = codes_out[0];
  assign result.code_two   = codes_out[1];
  assign result.code_three = codes_out[2];
  assign result.code_four  = codes_out[3];

  // Advance the word state; drop it all back to empty on the word's last beat
  always_ff @(posedge clk) begin
    if (rst || (accept && beat.last)) begin
      at_start   <= 1'b1;
      first_char <= '0;
      prev_code  <= CODE_NONE;
      count      <= '0;
      for (int k = 0; k < CODE_DIGITS; k++) begin
        store[k] <= CODE_NONE;
      end
    end else if (accept) begin
      at_start   <= 1'b0;
      first_char <= first_next;
      prev_code  <= cur_code;
      if (take) begin
        count <= count + CNT_W'(1);
      end
      for (int k = 0; k < CODE_DIGITS; k++) begin
        store[k] <= store_next[k];
      end
    end
  end

endmodule

// ===== hdl/soundex_encoder.sv =====
// Top level of the soundex encoder: input handshake, word state and result register.
// Depends on sdx_pkg and sdx_word.
//
//   channel  | payload      | direction | handshake
//   ---------+--------------+-----------+--------------------------
//   char     | char_beat_t  | in        | char_valid / char_stall
//   code     | code_beat_t  | out       | code_valid / code_stall
//
// One character is taken per cycle unless char_stall is high; the word state updates in that same cycle.
// The code of a word is in the result register in the cycle after its last character is taken.
// The character channel stalls only while a code waits in the result register and
// the receiver stalls too; the single result register sets that limit.
// Synchronous reset empties the word state and the result register.
module soundex_encoder import sdx_pkg::*; #(
  parameter int unsigned CODE_DIGITS = CODE_DIGITS_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       char_valid,
  output logic       char_stall,
  input  char_beat_t char_beat,
  output logic       code_valid,
  input  logic       code_stall,
  output code_beat_t code_beat
);

  logic       char_take;
  code_beat_t word_code;

  // Hold the input only while a code is parked and not being taken
  assign char_stall = code_valid && code_stall;
  assign char_take  = char_valid && !char_stall;

  sdx_word #(
    .CODE_DIGITS(CODE_DIGITS)
  ) u_word (
    .clk    (clk),
    .rst    (rst),
    .accept (char_take),
    .beat   (char_beat),
    .result (word_code)
  );

  // Result register: load on a word's last beat, release when taken
  always_ff @(posedge clk) begin
    if (rst) begin
      code_valid <= 1'b0;
    end else if (char_take && char_beat.last) begin
      code_valid <= 1'b1;
    end else if (!code_stall) begin
      code_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (char_take && char_beat.last) begin
      code_beat <= word_code;
    end
  end

endmodule

// ===== hdl/sdx_checker.sv =====
// Port-level checks for the soundex encoder, attached to every instance by bind.
// Depends on sdx_pkg and soundex_encoder.
module sdx_checker import sdx_pkg::*; (
  input logic       clk,
  input logic       rst,
  input logic       char_valid,
  input logic       char_stall,
  input char_beat_t char_beat,
  input logic       code_valid,
  input logic       code_stall,
  input code_beat_t code_beat
);

  // A stalled code beat stays and holds its payload
  a_code_hold: assert property (@(posedge clk) disable iff (rst)
    code_valid && code_stall |=> code_valid && $stable(code_beat))
    else $error("code beat dropped or changed while stalled");

  // Every accepted last character yields a code beat next cycle
  a_last_gives_code: assert property (@(posedge clk) disable iff (rst)
    char_valid && !char_stall && char_beat.last |=> code_valid)
    else $error("no code after last character");

  // A new code beat only follows an accepted last character
  a_code_has_cause: assert property (@(posedge clk) disable iff (rst)
    $rose(code_valid) |-> $past(char_valid && !char_stall && char_beat.last))
    else $error("code beat without a finished word");

  // Input stalls only when the result register is full and held
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    char_stall |-> code_valid && code_stall)
    else $error("character stall without a held code");

endmodule

bind soundex_encoder sdx_checker u_sdx_checker (
  .clk        (clk),
  .rst        (rst),
  .char_valid (char_valid),
  .char_stall (char_stall),
  .char_beat  (char_beat),
  .code_valid (code_valid),
  .code_stall (code_stall),
  .code_beat  (code_beat)
);
